[rtl/sdk_pkg.sv]
`timescale 1ns / 1ps
package sdk_pkg;
    localparam int MAX_WHEELS_DEF   = 4;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int REG_COUNT        = 7;
    localparam logic [2:0] REG_OFS0  = 3'd0;
    localparam logic [2:0] REG_OFS1  = 3'd1;
    localparam logic [2:0] REG_OFS2  = 3'd2;
    localparam logic [2:0] REG_OFS3  = 3'd3;
    localparam logic [2:0] REG_INVR  = 3'd4;
    localparam logic [2:0] REG_OPT   = 3'd5;
    localparam logic [2:0] REG_COUNT_IDX = 3'd6;
    localparam logic [2:0] REG_NONE  = 3'd7;
    localparam logic signed [27:0] PI_Q      = 28'sd205887;
    localparam logic signed [27:0] TWO_PI_Q  = 28'sd411775;
    localparam logic signed [27:0] HALF_PI_Q = 28'sd102944;
    localparam logic [15:0] GAIN_Q16 = 16'd39797;
    localparam int VW = 36;

    // One wheel job handed from the front to the back.
    typedef struct packed {
        logic signed [VW-1:0] ex;
        logic signed [VW-1:0] ey;
        logic signed [23:0]   cur;
        logic                 opt;
        logic                 zero_cmd;
        logic [1:0]           idx;
        logic                 last;
    } job_t;

    function automatic logic [17:0] atan_tab(input int i);
        case (i)
            0: atan_tab = 18'd51472;  1: atan_tab = 18'd30385;
            2: atan_tab = 18'd16055;  3: atan_tab = 18'd8150;
            4: atan_tab = 18'd4091;   5: atan_tab = 18'd2047;
            6: atan_tab = 18'd1024;   7: atan_tab = 18'd512;
            8: atan_tab = 18'd256;    9: atan_tab = 18'd128;
            10: atan_tab = 18'd64;    11: atan_tab = 18'd32;
            12: atan_tab = 18'd16;    13: atan_tab = 18'd8;
            14: atan_tab = 18'd4;     15: atan_tab = 18'd2;
            16: atan_tab = 18'd1;
            default: atan_tab = 18'd0;
        endcase
    endfunction
endpackage

[rtl/sdk_front.sv]
`timescale 1ns / 1ps
module sdk_front #(
    parameter int MAX_WHEELS = sdk_pkg::MAX_WHEELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [147:0]        in_data,
    input  logic [31:0]         ofs [4],
    input  logic                opt,
    input  logic [2:0]          count,
    output logic                job_valid,
    input  logic                job_ready,
    output sdk_pkg::job_t       job
);
    localparam int VW = sdk_pkg::VW;

    logic [147:0] cmd_reg;
    logic         busy_reg;
    logic [1:0]   wi_reg;
    logic [2:0]   n;
    logic signed [15:0] vx, vy, wz, px, py;
    logic [1:0]   ofs_idx;
    logic         zero_cmd;
    logic         mul_valid_reg;
    logic signed [31:0] pwx_reg, pwy_reg;
    sdk_pkg::job_t pend_reg;
    logic         pend_last;
    logic         stall;

    always_comb
    begin
        n = (count > 3'(MAX_WHEELS)) ? 3'(MAX_WHEELS) : count;
    end
    // A command is always taken when idle; with no wheels in use it is dropped.
    assign in_ready = !busy_reg;
    assign vx = cmd_reg[15:0];
    assign vy = cmd_reg[31:16];
    assign wz = cmd_reg[47:32];
    assign ofs_idx = wi_reg;
    assign px = ofs[ofs_idx][31:16];
    assign py = ofs[ofs_idx][15:0];
    assign zero_cmd = vx == 16'sd0 && vy == 16'sd0 && wz == 16'sd0;
    assign stall = mul_valid_reg && !job_ready;
    assign job_valid = mul_valid_reg;
    assign pend_last = (3'(wi_reg) + 3'd1) == n;

    always_comb
    begin
        job = pend_reg;
        if (pend_reg.zero_cmd)
        begin
            job.ex = -(VW'(signed'(pend_reg.ex[15:0])) * 36'sd1024);
            job.ey = VW'(signed'(pend_reg.ey[15:0])) * 36'sd1024;
        end
        else
        begin
            job.ex = VW'(signed'(pend_reg.ex[15:0])) * 36'sd32768 - VW'(pwy_reg);
            job.ey = VW'(signed'(pend_reg.ey[15:0])) * 36'sd32768 + VW'(pwx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            wi_reg        <= 2'd0;
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cmd_reg  <= in_data;
                busy_reg <= n != 3'd0;
                wi_reg   <= 2'd0;
            end
            if (!stall)
            begin
                mul_valid_reg <= busy_reg;
                if (busy_reg)
                begin
                    pwx_reg <= wz * px;
                    pwy_reg <= wz * py;
                    pend_reg.ex <= zero_cmd ? VW'(py) : VW'(vx);
                    pend_reg.ey <= zero_cmd ? VW'(px) : VW'(vy);
                    pend_reg.cur <= cmd_reg[48 + 24*ofs_idx +: 24];
                    pend_reg.opt <= opt && cmd_reg[144 + ofs_idx];
                    pend_reg.zero_cmd <= zero_cmd;
                    pend_reg.idx <= wi_reg;
                    pend_reg.last <= pend_last;
                    if (pend_last)
                        busy_reg <= 1'b0;
                    else
                        wi_reg <= wi_reg + 2'd1;
                end
            end
        end
    end
endmodule

[rtl/sdk_queue.sv]
`timescale 1ns / 1ps
module sdk_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  sdk_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output sdk_pkg::job_t rd_data
);
    sdk_pkg::job_t mem_reg [4];
    logic [2:0] wp_reg, rp_reg;

    assign wr_ready = (wp_reg - rp_reg) != 3'd4;
    assign rd_valid = wp_reg != rp_reg;
    assign rd_data  = mem_reg[rp_reg[1:0]];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg[1:0]] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 3'd0;
            rp_reg <= 3'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= wp_reg + 3'd1;
            if (rd_valid && rd_ready)
                rp_reg <= rp_reg + 3'd1;
        end
    end
endmodule

[rtl/sdk_back.sv]
`timescale 1ns / 1ps
module sdk_back #(
    parameter int CORDIC_STEPS = sdk_pkg::CORDIC_STEPS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  sdk_pkg::job_t job,
    input  logic [15:0]   inv_r,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [47:0]   out_data,
    output logic          out_last
);
    localparam int VW = sdk_pkg::VW;
    localparam int SW = $clog2(CORDIC_STEPS + 1);
    typedef enum logic [2:0] {S_IDLE, S_ITER, S_MAG, S_SPD, S_WRAP, S_DONE} state_t;

    state_t state_reg;
    logic [SW-1:0] step_reg;
    logic signed [VW+1:0] x_reg, y_reg;
    logic signed [27:0]   z_reg;
    sdk_pkg::job_t j_reg;
    logic [37:0] mag_reg;
    logic [53:0] spd_raw;
    logic [19:0] spd_reg;
    logic        neg_reg;
    logic signed [27:0] d_reg;
    logic signed [27:0] ang;
    logic [1:0]  oi_reg;
    logic signed [23:0] ot_reg;
    logic signed [19:0] os_reg;
    logic        ol_reg, ov_reg;
    logic        free;
    logic [SW-1:0] last_step;

    assign last_step = SW'(CORDIC_STEPS - 1);
    assign free = !ov_reg || out_ready;
    assign job_ready = state_reg == S_IDLE;
    assign out_valid = ov_reg;
    assign out_last  = ol_reg;
    assign out_data  = {2'b00, os_reg, ot_reg, oi_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            if (ov_reg && out_ready && state_reg != S_DONE)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        j_reg    <= job;
                        step_reg <= '0;
                        if (job.ex == 0 && job.ey == 0)
                        begin
                            x_reg <= '0; y_reg <= '0; z_reg <= '0;
                            state_reg <= S_MAG;
                        end
                        else if (job.ex < 0 && job.ey == 0)
                        begin
                            x_reg <= -(VW+2)'(job.ex); y_reg <= '0; z_reg <= sdk_pkg::PI_Q;
                            state_reg <= S_MAG;
                        end
                        else if (job.ex < 0 && job.ey > 0)
                        begin
                            x_reg <= (VW+2)'(job.ey); y_reg <= -(VW+2)'(job.ex);
                            z_reg <= sdk_pkg::HALF_PI_Q;
                            state_reg <= S_ITER;
                        end
                        else if (job.ex < 0)
                        begin
                            x_reg <= -(VW+2)'(job.ey); y_reg <= (VW+2)'(job.ex);
                            z_reg <= -sdk_pkg::HALF_PI_Q;
                            state_reg <= S_ITER;
                        end
                        else
                        begin
                            x_reg <= (VW+2)'(job.ex); y_reg <= (VW+2)'(job.ey);
                            z_reg <= '0;
                            state_reg <= S_ITER;
                        end
                    end
                end
                S_ITER:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + (y_reg >>> step_reg);
                        y_reg <= y_reg - (x_reg >>> step_reg);
                        z_reg <= z_reg + 28'(sdk_pkg::atan_tab(int'(step_reg)));
                    end
                    else
                    begin
                        x_reg <= x_reg - (y_reg >>> step_reg);
                        y_reg <= y_reg + (x_reg >>> step_reg);
                        z_reg <= z_reg - 28'(sdk_pkg::atan_tab(int'(step_reg)));
                    end
                    if (step_reg == last_step)
                        state_reg <= S_MAG;
                    else
                        step_reg <= step_reg + SW'(1);
                end
                S_MAG:
                begin
                    mag_reg <= 38'(((x_reg < 0 ? 54'd0 : 54'(x_reg[VW:0]))
                                    * 54'(sdk_pkg::GAIN_Q16) + 54'd32768) >> 16);
                    state_reg <= S_SPD;
                end
                S_SPD:
                begin
                    if (j_reg.zero_cmd)
                        spd_reg <= 20'd0;
                    else if (spd_raw > 54'd524287)
                        spd_reg <= 20'd524287;
                    else
                        spd_reg <= spd_raw[19:0];
                    d_reg <= z_reg - 28'(j_reg.cur);
                    neg_reg <= 1'b0;
                    state_reg <= j_reg.opt ? S_WRAP : S_DONE;
                end
                S_WRAP:
                begin
                    if (d_reg > sdk_pkg::PI_Q)
                        d_reg <= d_reg - sdk_pkg::TWO_PI_Q;
                    else if (d_reg < -sdk_pkg::PI_Q)
                        d_reg <= d_reg + sdk_pkg::TWO_PI_Q;
                    else
                    begin
                        if (d_reg > sdk_pkg::HALF_PI_Q)
                        begin
                            d_reg <= d_reg - sdk_pkg::PI_Q; neg_reg <= 1'b1;
                        end
                        else if (d_reg < -sdk_pkg::HALF_PI_Q)
                        begin
                            d_reg <= d_reg + sdk_pkg::PI_Q; neg_reg <= 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (free)
                    begin
                        oi_reg <= j_reg.idx;
                        ol_reg <= j_reg.last;
                        if (ang > 28'sd8388607)
                            ot_reg <= 24'sh7FFFFF;
                        else if (ang < -28'sd8388608)
                            ot_reg <= 24'sh800000;
                        else
                            ot_reg <= ang[23:0];
                        os_reg <= neg_reg ? -signed'(spd_reg) : signed'(spd_reg);
                        ov_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign spd_raw = (54'(mag_reg) * 54'(inv_r) + 54'd4194304) >> 23;
    assign ang = j_reg.opt ? 28'(j_reg.cur) + d_reg : z_reg;
endmodule

[rtl/swerve_drive_kinematics_unit.sv]
`timescale 1ns / 1ps
// Swerve drive inverse kinematics unit.
// The s_axis channel carries one chassis command per transaction: vx, vy,
// wz, the four current steer angles and the angle_known mask. For each
// wheel in use the m_axis channel gives one transaction holding the wheel
// index, steer target and wheel speed, with tlast on the last wheel.
// The front stage walks the wheels, forms each wheel's ground velocity
// with one registered multiply pair, and pushes a job into a four-deep
// queue. The back stage runs a CORDIC vectoring loop, one step per cycle,
// then scales the length, optionally unwraps the angle, and registers the
// result. A zero vector or one on the negative x axis skips the loop. The
// front is ready for the next command once it has registered the job for
// the last wheel of the previous one; a command with no wheels in use is
// accepted and gives no result. Reset clears all control state and loads
// the register defaults. When the receiver stalls, the result register
// holds, the back stage waits, the queue fills and the front stops taking
// commands. Configuration writes are meant to be issued only while the
// unit is idle.
module swerve_drive_kinematics_unit #(
    parameter int MAX_WHEELS   = sdk_pkg::MAX_WHEELS_DEF,
    parameter int CORDIC_STEPS = sdk_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd_vx, cmd_vy, cmd_wz, steer_now_0..3, angle_known
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // wheel_index, steer_target, wheel_speed
    output logic [47:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    logic [31:0] ofs_reg [4];
    logic [15:0] invr_reg;
    logic        opt_reg;
    logic [2:0]  count_reg;
    logic        fj_valid, fj_ready, bj_valid, bj_ready;
    sdk_pkg::job_t fj, bj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg[0] <= 32'h10001000;
            ofs_reg[1] <= 32'hF0001000;
            ofs_reg[2] <= 32'hF000F000;
            ofs_reg[3] <= 32'h1000F000;
            invr_reg   <= 16'd5120;
            opt_reg    <= 1'b0;
            count_reg  <= 3'd4;
        end
        else if (cfg_we)
        begin
            if (cfg_index <= sdk_pkg::REG_OFS3)
                ofs_reg[cfg_index[1:0]] <= cfg_data;
            else if (cfg_index == sdk_pkg::REG_INVR)
                invr_reg <= cfg_data[15:0];
            else if (cfg_index == sdk_pkg::REG_OPT)
                opt_reg <= cfg_data[0];
            else if (cfg_index == sdk_pkg::REG_COUNT_IDX)
                count_reg <= cfg_data[2:0];
        end
    end

    sdk_front #(.MAX_WHEELS(MAX_WHEELS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata[147:0]),
        .ofs(ofs_reg), .opt(opt_reg), .count(count_reg),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    sdk_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    sdk_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .inv_r(invr_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast)
    );
endmodule

[rtl/sdk_checker.sv]
`timescale 1ns / 1ps
module sdk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output changed under stall");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:46] == 2'b00)
        else $error("padding bits set");
    a_reset: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("valid during reset");
endmodule

bind swerve_drive_kinematics_unit sdk_checker u_sdk_checker (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the swerve drive kinematics unit.
// Commands go in on the s_axis channel and per-wheel results come back on
// the m_axis channel. A scoreboard object keeps its own copy of the
// configuration registers. For every accepted command it works out the
// expected wheel results and queues them. Every result that comes out is
// then checked against the oldest queued entry.
module tb;
    // One chassis command as it travels on s_axis.
    typedef struct packed {
        logic [3:0]        known;
        logic [3:0][23:0]  steer;
        logic signed [15:0] wz;
        logic signed [15:0] vy;
        logic signed [15:0] vx;
    } chassis_cmd_t;

    // One expected wheel result.
    typedef struct {
        logic [1:0]         idx;
        logic signed [23:0] steer;
        logic signed [19:0] speed;
        logic               last;
    } wheel_result_t;

    // The scoreboard holds a copy of the registers and computes the inverse
    // kinematics for each accepted command. It queues the wheel results in
    // wheel order.
    class steer_scoreboard;
        logic [31:0]   offs[4];
        logic [15:0]   invr;
        logic          opt;
        logic [2:0]    count;
        longint        atan_q[17];
        wheel_result_t expected[$];
        int            errors;

        function new();
            offs[0] = 32'h10001000;
            offs[1] = 32'hF0001000;
            offs[2] = 32'hF000F000;
            offs[3] = 32'h1000F000;
            invr = 16'd5120;
            opt = 1'b0;
            count = 3'd4;
            errors = 0;
            atan_q = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2, 1};
        endfunction

        function void write_reg(logic [2:0] index, logic [31:0] value);
            if (index <= sdk_pkg::REG_OFS3)
                offs[index - sdk_pkg::REG_OFS0] = value;
            else if (index == sdk_pkg::REG_INVR)
                invr = value[15:0];
            else if (index == sdk_pkg::REG_OPT)
                opt = value[0];
            else if (index == sdk_pkg::REG_COUNT_IDX)
                count = value[2:0];
        endfunction

        // Vectoring CORDIC. It returns the angle in units of 2^-16 rad and
        // gives back the length before the gain is applied.
        function longint vector_angle(longint x, longint y, output longint len);
            longint z;
            longint t;
            longint dx;
            longint dy;
            z = 0;
            if (x == 0 && y == 0) begin
                len = 0;
                return 0;
            end
            if (x < 0 && y == 0) begin
                len = -x;
                return longint'(sdk_pkg::PI_Q);
            end
            // A vector in the left half-plane is first turned by a quarter turn.
            if (x < 0) begin
                t = x;
                if (y > 0) begin
                    x = y;
                    y = -t;
                    z = longint'(sdk_pkg::HALF_PI_Q);
                end
                else begin
                    x = -y;
                    y = t;
                    z = -longint'(sdk_pkg::HALF_PI_Q);
                end
            end
            for (int i = 0; i < sdk_pkg::CORDIC_STEPS_DEF; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx;
                    y -= dy;
                    z += atan_q[i];
                end
                else begin
                    x -= dx;
                    y += dy;
                    z -= atan_q[i];
                end
            end
            len = (x < 0) ? 0 : x;
            return z;
        endfunction

        function void note_command(chassis_cmd_t c);
            longint vx, vy, wz, px, py, ex, ey, len, ang, spd, mag, s, cur, d;
            bit     all_zero;
            int     n;
            wheel_result_t r;
            vx = c.vx;
            vy = c.vy;
            wz = c.wz;
            all_zero = (vx == 0 && vy == 0 && wz == 0);
            n = (count > 4) ? 4 : count;
            for (int i = 0; i < n; i++) begin
                px = $signed(offs[i][31:16]);
                py = $signed(offs[i][15:0]);
                if (all_zero) begin
                    // With no command, the wheel points along the yaw circle.
                    ex = -py * 1024;
                    ey = px * 1024;
                end
                else begin
                    ex = vx * 32768 - wz * py;
                    ey = vy * 32768 + wz * px;
                end
                ang = vector_angle(ex, ey, len);
                if (all_zero) begin
                    spd = 0;
                end
                else begin
                    mag = (len * longint'(sdk_pkg::GAIN_Q16) + 32768) >> 16;
                    s = (mag * longint'(invr) + 4194304) >> 23;
                    spd = (s > 524287) ? 524287 : s;
                end
                if (opt && c.known[i]) begin
                    cur = $signed(c.steer[i]);
                    d = ang - cur;
                    while (d > longint'(sdk_pkg::PI_Q))
                        d -= longint'(sdk_pkg::TWO_PI_Q);
                    while (d < -longint'(sdk_pkg::PI_Q))
                        d += longint'(sdk_pkg::TWO_PI_Q);
                    // More than a quarter turn away, the wheel runs backward.
                    if (d > longint'(sdk_pkg::HALF_PI_Q)) begin
                        d -= longint'(sdk_pkg::PI_Q);
                        spd = -spd;
                    end
                    else if (d < -longint'(sdk_pkg::HALF_PI_Q)) begin
                        d += longint'(sdk_pkg::PI_Q);
                        spd = -spd;
                    end
                    ang = cur + d;
                end
                if (ang > 8388607)
                    ang = 8388607;
                if (ang < -8388608)
                    ang = -8388608;
                r.idx = i[1:0];
                r.steer = ang[23:0];
                r.speed = spd[19:0];
                r.last = (i + 1 == n);
                expected.push_back(r);
            end
        endfunction

        function void check_result(logic [47:0] data, logic last);
            wheel_result_t e;
            if (expected.size() == 0) begin
                $display("%0t: unexpected result, actual tdata=%h last=%b",
                         $time, data, last);
                errors++;
                return;
            end
            e = expected.pop_front();
            if (data[1:0] !== e.idx) begin
                $display("%0t: wheel_index mismatch, expected %0d actual %0d",
                         $time, e.idx, data[1:0]);
                errors++;
            end
            if (data[25:2] !== e.steer) begin
                $display("%0t: steer_target mismatch, expected %0d actual %0d",
                         $time, e.steer, $signed(data[25:2]));
                errors++;
            end
            if (data[45:26] !== e.speed) begin
                $display("%0t: wheel_speed mismatch, expected %0d actual %0d",
                         $time, e.speed, $signed(data[45:26]));
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last mismatch, expected %b actual %b",
                         $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 3000;  // cycles with no transaction at all
    localparam int SETTLE      = 150;   // four wheels plus unwrap, with margin
    localparam int HOLD_OFF    = 400;   // long receiver stall

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // cmd_vx, cmd_vy, cmd_wz, steer_now_0..3, angle_known
    logic [151:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // wheel_index, steer_target, wheel_speed
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    steer_scoreboard sb;
    bit no_idle;       // when set, neither side inserts gaps
    bit hold_req;      // asks the receiver for one long stall
    int rx_gap;
    int hold_cnt;
    int quiet_cycles;

    swerve_drive_kinematics_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Most gaps are short and a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver side: checks results, applies back-pressure and runs the
    // watchdog that ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = HOLD_OFF;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 15)
                    rx_gap = pick_gap();
            end
        end
    end

    // Offers one command and returns once it has been accepted. The valid
    // is lowered only when a gap comes first.
    task automatic send_cmd(chassis_cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, c};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_command(c);
    endtask

    // Stops offering and waits until every expected result has come out,
    // then lets the unit finish work that gives no result.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(index, value);
    endtask

    function automatic logic signed [15:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 1024) - 512);
            1: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic chassis_cmd_t rand_cmd();
        chassis_cmd_t c;
        c.known = 4'($urandom);
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 3) == 0)
                c.steer[i] = 24'($urandom);
            else
                c.steer[i] = 24'($urandom_range(0, 1200000) - 600000);
        end
        if ($urandom_range(0, 99) < 4) begin
            c.vx = 0;
            c.vy = 0;
            c.wz = 0;
        end
        else begin
            c.vx = rand_vel();
            c.vy = rand_vel();
            c.wz = rand_vel();
        end
        return c;
    endfunction

    task automatic send_random(int n);
        for (int k = 0; k < n; k++)
            send_cmd(rand_cmd());
    endtask

    task automatic send_simple(logic signed [15:0] vx, logic signed [15:0] vy,
                               logic signed [15:0] wz, logic [23:0] steer,
                               logic [3:0] known);
        chassis_cmd_t c;
        c.vx = vx;
        c.vy = vy;
        c.wz = wz;
        c.steer = {4{steer}};
        c.known = known;
        send_cmd(c);
    endtask

    task automatic random_offsets();
        for (int i = 0; i < 4; i++)
            write_reg(3'(sdk_pkg::REG_OFS0 + i), $urandom);
    endtask

    initial
    begin
        clk = 0;
        sb = new();
        no_idle = 0;
        hold_req = 0;
        rx_gap = 0;
        hold_cnt = 0;
        quiet_cycles = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed commands with the reset register values: the all-zero
        // command, field extremes and a pure backward vector that lands on
        // the negative x axis.
        send_simple(0, 0, 0, 0, 4'hF);
        send_simple(16'sh7FFF, 0, 0, 0, 0);
        send_simple(-16'sh8000, 0, 0, 0, 0);
        send_simple(0, 16'sh7FFF, 0, 0, 0);
        send_simple(0, -16'sh8000, 0, 0, 0);
        send_simple(0, 0, 16'sh7FFF, 0, 0);
        send_simple(0, 0, -16'sh8000, 0, 0);
        send_simple(-16'sd256, 0, 0, 0, 0);
        send_simple(-16'sh8000, -16'sh8000, -16'sh8000, 24'h800000, 4'hF);
        send_simple(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 24'h7FFFFF, 4'hF);
        drain();

        // Optimization on: the current angle sits at the extremes of its
        // range, so the target saturates, and far beyond a full turn.
        write_reg(sdk_pkg::REG_OPT, 32'd1);
        send_simple(16'sd300, 16'sd10, 0, 24'h7FFFFF, 4'hF);
        send_simple(-16'sd300, 16'sd10, 0, 24'h800000, 4'hF);
        send_simple(-16'sd300, -16'sd5, 0, 24'd823100, 4'hF);
        send_simple(16'sd100, 16'sd400, 0, -24'sd300000, 4'h5);
        send_simple(0, 0, 0, 24'd205887, 4'hA);
        drain();

        // A wheel placed at the center sees a zero vector under pure yaw.
        write_reg(sdk_pkg::REG_OFS0, 32'd0);
        send_simple(0, 0, 16'sd1000, 0, 4'hF);
        send_simple(0, 0, 0, 0, 4'hF);
        send_random(60);
        drain();

        // Random wheel positions and the largest inverse radius. Halfway
        // through, the sender waits for every result.
        random_offsets();
        write_reg(sdk_pkg::REG_INVR, 32'hFFFF);
        send_random(40);
        drain();
        send_random(40);
        drain();

        // No inverse radius, so every speed is zero, and a wheel count
        // above the maximum, which acts as four.
        random_offsets();
        write_reg(sdk_pkg::REG_INVR, 32'd0);
        write_reg(sdk_pkg::REG_COUNT_IDX, 32'd7);
        send_random(40);
        drain();

        // Smallest inverse radius and a single wheel, with no optimization.
        // The receiver holds off long enough that the unit stalls its input.
        write_reg(sdk_pkg::REG_INVR, 32'd1);
        write_reg(sdk_pkg::REG_COUNT_IDX, 32'd1);
        write_reg(sdk_pkg::REG_OPT, 32'd0);
        hold_req = 1;
        send_random(40);
        drain();

        // A wheel count of zero gives no results at all.
        write_reg(sdk_pkg::REG_COUNT_IDX, 32'd0);
        send_random(10);
        drain();

        // Wheel positions at the corners of their range.
        write_reg(sdk_pkg::REG_OFS0, 32'h7FFF7FFF);
        write_reg(sdk_pkg::REG_OFS1, 32'h80008000);
        write_reg(sdk_pkg::REG_OFS2, 32'h7FFF8000);
        write_reg(sdk_pkg::REG_OFS3, 32'h80007FFF);
        write_reg(sdk_pkg::REG_INVR, $urandom_range(1, 65535));
        write_reg(sdk_pkg::REG_OPT, 32'd1);
        write_reg(sdk_pkg::REG_COUNT_IDX, 32'd3);
        send_random(80);
        drain();

        // Two wheels with no idling on either side; a write to the unused
        // register index must change nothing.
        no_idle = 1;
        write_reg(sdk_pkg::REG_NONE, 32'hFFFFFFFF);
        random_offsets();
        write_reg(sdk_pkg::REG_COUNT_IDX, 32'd2);
        send_random(60);
        drain();
        no_idle = 0;

        // Back to typical wheel positions with a count of five.
        write_reg(sdk_pkg::REG_OFS0, 32'h10001000);
        write_reg(sdk_pkg::REG_OFS1, 32'hF0001000);
        write_reg(sdk_pkg::REG_OFS2, 32'hF000F000);
        write_reg(sdk_pkg::REG_OFS3, 32'h1000F000);
        write_reg(sdk_pkg::REG_INVR, 32'd5120);
        write_reg(sdk_pkg::REG_COUNT_IDX, 32'd5);
        send_random(60);
        drain();

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
